// ===== rtl/core/ils_pkg.sv =====
package ils_pkg;

    // List depth; the index, count and compare widths below follow from it
    localparam int CAPACITY = 64;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int ECNT_W   = 7;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // common width for position, index and count compares
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic signed [VAL_W-1:0] value_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_SET    = 3'd2,
        KIND_READ   = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        value_t            item_value;
    } in_item_t;

    typedef struct packed {
        value_t              read_value;
        logic [STATUS_W-1:0] status;
        logic [ECNT_W-1:0]   entry_count;
    } out_item_t;

    // Per-cycle operation broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SET,
        CELL_SCAN
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [CMP_W-1:0] pos;
        value_t           value;
    } cell_cmd_t;

    function automatic logic [ECNT_W-1:0] count_field(input logic [CNT_W-1:0] cnt);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(cnt);
        return wide[ECNT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/ils_cell.sv =====
module ils_cell
    import ils_pkg::*;
(
    input  logic             clk,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] idx,
    input  value_t           left_entry,
    input  value_t           right_entry,
    input  value_t           bus_in,
    output value_t           entry,
    output value_t           bus_out
);

    value_t entry_reg;
    value_t entry_next;
    value_t bus_reg;
    value_t bus_next;

    logic [CMP_W-1:0] idx_ext;
    logic             at_pos;
    logic             past_pos;

    assign idx_ext  = CMP_W'(idx);
    assign at_pos   = (idx_ext == cmd.pos);
    assign past_pos = (idx_ext > cmd.pos);

    always_comb
    begin
        entry_next = entry_reg;
        bus_next   = bus_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
            end
            CELL_INSERT:
            begin
                if (past_pos)
                begin
                    entry_next = left_entry;
                end
                else if (at_pos)
                begin
                    entry_next = cmd.value;
                end
            end
            CELL_REMOVE:
            begin
                if (past_pos || at_pos)
                begin
                    entry_next = right_entry;
                end
            end
            CELL_SET:
            begin
                if (at_pos)
                begin
                    entry_next = cmd.value;
                end
            end
            CELL_SCAN:
            begin
                // selected cell drops its entry on the bus, others pass it down
                bus_next = at_pos ? entry_reg : bus_in;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        bus_reg   <= bus_next;
    end

    assign entry   = entry_reg;
    assign bus_out = bus_reg;

endmodule

// ===== rtl/core/indexed_list_store.sv =====
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     in_item  (kind, position, item_value)
// out       output     out_valid / out_ready   out_item (read_value, status, entry_count)
//
// Insert, remove, set, clear and every rejected request: the result is registered on acceptance.
// Read that hits: enters a scan state; the read bus walks down the cell row
// one cell per cycle until the value reaches cell 0, then the result is registered.
// Reset clears the count and the control state; cell contents are undefined.
// A stalled out channel holds the result and blocks the next input transaction.
module indexed_list_store
    import ils_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CMP_W-1:0] scan_pos_reg;
    logic [CMP_W-1:0] scan_cnt_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    // Cell row wiring
    value_t entry_w  [CAPACITY];
    value_t bus_w    [CAPACITY];
    value_t left_w   [CAPACITY];
    value_t right_w  [CAPACITY];
    value_t bus_in_w [CAPACITY];

    cell_cmd_t cmd;

    logic             out_free;
    logic             accept;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             is_empty;
    logic             is_full;
    logic             pos_oob;       // position at or past count
    logic             ins_oob;       // position past count
    logic             scan_done;     // read value has reached cell 0
    logic             load_out;      // result register takes a new transaction

    // Decoded request
    cell_op_t         req_op;
    status_t          req_status;
    logic [CNT_W-1:0] req_count;
    logic             req_read;      // read that hits: goes to the scan

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    assign pos_ext  = CMP_W'(in_item.position);
    assign cnt_ext  = CMP_W'(count_reg);
    assign is_empty = (count_reg == '0);
    assign is_full  = (cnt_ext >= CMP_W'(CAPACITY));
    assign pos_oob  = (pos_ext >= cnt_ext);
    assign ins_oob  = (pos_ext > cnt_ext);

    assign scan_done = (state_reg == ST_SCAN) && (scan_cnt_reg > scan_pos_reg);
    assign load_out  = (accept && !req_read) || (scan_done && out_free);

    // Status precedence follows the list rules: full before range on insert,
    // empty before range on remove, set and read.
    always_comb
    begin
        req_op     = CELL_HOLD;
        req_status = STATUS_OK;
        req_count  = count_reg;
        req_read   = 1'b0;
        unique case (in_item.kind)
            KIND_INSERT:
            begin
                if (is_full)
                begin
                    req_status = STATUS_FULL;
                end
                else if (ins_oob)
                begin
                    req_status = STATUS_RANGE;
                end
                else
                begin
                    req_op    = CELL_INSERT;
                    req_count = count_reg + CNT_W'(1);
                end
            end
            KIND_REMOVE:
            begin
                if (is_empty)
                begin
                    req_status = STATUS_EMPTY;
                end
                else if (pos_oob)
                begin
                    req_status = STATUS_RANGE;
                end
                else
                begin
                    req_op    = CELL_REMOVE;
                    req_count = count_reg - CNT_W'(1);
                end
            end
            KIND_SET:
            begin
                if (is_empty)
                begin
                    req_status = STATUS_EMPTY;
                end
                else if (pos_oob)
                begin
                    req_status = STATUS_RANGE;
                end
                else
                begin
                    req_op = CELL_SET;
                end
            end
            KIND_READ:
            begin
                if (is_empty)
                begin
                    req_status = STATUS_EMPTY;
                end
                else if (pos_oob)
                begin
                    req_status = STATUS_RANGE;
                end
                else
                begin
                    req_read = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                req_count = '0;
            end
            default:
            begin
                // unused kinds: no change, ok status
            end
        endcase
    end

    // Broadcast command: the accepted request for one cycle, or the scan
    // while a read is walking down the row.
    always_comb
    begin
        cmd.op    = CELL_HOLD;
        cmd.pos   = pos_ext;
        cmd.value = in_item.item_value;
        if (state_reg == ST_SCAN)
        begin
            cmd.op  = CELL_SCAN;
            cmd.pos = scan_pos_reg;
        end
        else if (accept)
        begin
            cmd.op = req_op;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign left_w[i] = cmd.value;
            end
            else
            begin : g_mid_l
                assign left_w[i] = entry_w[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_w[i]  = '0;
                assign bus_in_w[i] = '0;
            end
            else
            begin : g_mid_r
                assign right_w[i]  = entry_w[i+1];
                assign bus_in_w[i] = bus_w[i+1];
            end

            ils_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .idx         (IDX_W'(i)),
                .left_entry  (left_w[i]),
                .right_entry (right_w[i]),
                .bus_in      (bus_in_w[i]),
                .entry       (entry_w[i]),
                .bus_out     (bus_w[i])
            );
        end
    endgenerate

    // Control and result register. A read waits in ST_SCAN until the value
    // has reached cell 0, then posts it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_pos_reg  <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= req_count;
                        if (req_read)
                        begin
                            state_reg    <= ST_SCAN;
                            scan_pos_reg <= pos_ext;
                            scan_cnt_reg <= '0;
                        end
                        else
                        begin
                            out_item_reg.read_value  <= '0;
                            out_item_reg.status      <= req_status;
                            out_item_reg.entry_count <= count_field(req_count);
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_cnt_reg > scan_pos_reg)
                    begin
                        if (out_free)
                        begin
                            state_reg                <= ST_IDLE;
                            out_item_reg.read_value  <= bus_w[0];
                            out_item_reg.status      <= STATUS_OK;
                            out_item_reg.entry_count <= count_field(count_reg);
                        end
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + CMP_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
